FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge outside reset
`define BPMF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every clock edge outside reset
`define BPMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bpmf_pkg.sv
// package: types, codes and constants of the banded priority multi fifo
`default_nettype none
package bpmf_pkg;

    localparam int NUM_LEVELS      = 5;
    localparam int NUM_BANDS       = NUM_LEVELS - 1;
    localparam int DEF_LEVEL_DEPTH = 16;
    localparam int VAL_W           = 7;
    localparam int LVL_W           = 3;
    localparam int CFG_IDX_W       = 3;

    localparam logic [VAL_W-1:0] VALUE_MIN = 7'd50;
    localparam logic [VAL_W-1:0] VALUE_MAX = 7'd100;

    // band register reset values, top band first
    localparam logic [VAL_W-1:0] BAND_TOP_RST    = 7'd89;
    localparam logic [VAL_W-1:0] BAND_SECOND_RST = 7'd79;
    localparam logic [VAL_W-1:0] BAND_THIRD_RST  = 7'd69;
    localparam logic [VAL_W-1:0] BAND_FOURTH_RST = 7'd59;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_THIRD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_FOURTH = 3'd3;

    // operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [2:0] {
        ST_ENQ   = 3'd0,
        ST_DEQ   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_FULL  = 3'd3,
        ST_RANGE = 3'd4
    } t_status;

    typedef logic [VAL_W-1:0] t_bands [NUM_BANDS];

    // outcome of one item, passed from the controller to the result stage
    typedef struct packed {
        t_status            status;
        logic [LVL_W-1:0]   level;
        logic               is_deq;
    } t_op_info;

endpackage
`default_nettype wire

FILE: rtl/bpmf_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module bpmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/bpmf_ctrl.sv
// level controller: band classify, priority pick, head/tail pointers and counts
`default_nettype none
module bpmf_ctrl #(
    parameter int LEVEL_DEPTH = bpmf_pkg::DEF_LEVEL_DEPTH,
    parameter int ADDR_W      = ($clog2(bpmf_pkg::NUM_LEVELS * LEVEL_DEPTH) > 0)
                                ? $clog2(bpmf_pkg::NUM_LEVELS * LEVEL_DEPTH) : 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic                        i_func,
    input  wire logic [bpmf_pkg::VAL_W-1:0]  i_value,
    input  wire bpmf_pkg::t_bands            i_bands,
    output bpmf_pkg::t_op_info               o_info,
    output logic                             o_ram_we,
    output logic                             o_ram_re,
    output logic [ADDR_W-1:0]                o_ram_addr
);
    import bpmf_pkg::*;

    localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LEVEL_DEPTH);

    logic [PTR_W-1:0] r_head [NUM_LEVELS];
    logic [PTR_W-1:0] r_tail [NUM_LEVELS];
    logic [CNT_W-1:0] r_count [NUM_LEVELS];

    logic [LVL_W-1:0] enq_level;
    logic [LVL_W-1:0] deq_level;
    logic             any_busy;
    logic             in_range;
    logic             enq_ok;
    logic             deq_ok;
    logic [PTR_W-1:0] sel_ptr;
    logic [LVL_W-1:0] sel_level;

    // band cascade, first match wins
    always_comb begin
        priority if (i_value > i_bands[0]) begin
            enq_level = LVL_W'(0);
        end else if (i_value > i_bands[1]) begin
            enq_level = LVL_W'(1);
        end else if (i_value > i_bands[2]) begin
            enq_level = LVL_W'(2);
        end else if (i_value > i_bands[3]) begin
            enq_level = LVL_W'(3);
        end else begin
            enq_level = LVL_W'(4);
        end
    end

    // lowest-numbered non-empty level
    always_comb begin
        deq_level = '0;
        any_busy  = 1'b0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                deq_level = LVL_W'(i);
                any_busy  = 1'b1;
            end
        end
    end

    assign in_range = (i_value >= VALUE_MIN) && (i_value <= VALUE_MAX);

    // outcome of the item
    always_comb begin
        o_info.is_deq = 1'b0;
        o_info.level  = '0;
        o_info.status = ST_EMPTY;
        enq_ok        = 1'b0;
        deq_ok        = 1'b0;
        if (i_func == FUNC_ENQ) begin
            if (!in_range) begin
                o_info.status = ST_RANGE;
            end else if (r_count[enq_level] == CNT_FULL) begin
                o_info.status = ST_FULL;
                o_info.level  = enq_level;
            end else begin
                o_info.status = ST_ENQ;
                o_info.level  = enq_level;
                enq_ok        = 1'b1;
            end
        end else if (any_busy) begin
            o_info.status = ST_DEQ;
            o_info.level  = deq_level;
            o_info.is_deq = 1'b1;
            deq_ok        = 1'b1;
        end
    end

    // store address: level base plus slot
    assign sel_level  = (i_func == FUNC_ENQ) ? enq_level : deq_level;
    assign sel_ptr    = (i_func == FUNC_ENQ) ? r_tail[sel_level] : r_head[sel_level];
    assign o_ram_addr = ADDR_W'(ADDR_W'(sel_level) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(sel_ptr);
    assign o_ram_we   = i_accept && enq_ok;
    assign o_ram_re   = i_accept && deq_ok;

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_accept) begin
            if (enq_ok) begin
                r_tail[enq_level]  <= (r_tail[enq_level] == PTR_LAST) ? '0
                                      : r_tail[enq_level] + PTR_W'(1);
                r_count[enq_level] <= r_count[enq_level] + CNT_W'(1);
            end
            if (deq_ok) begin
                r_head[deq_level]  <= (r_head[deq_level] == PTR_LAST) ? '0
                                      : r_head[deq_level] + PTR_W'(1);
                r_count[deq_level] <= r_count[deq_level] - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/banded_priority_multi_fifo.sv
// pipeline: an accepted item is registered in the store-read stage, then in the
// result register; a stalled result port holds both stages
// throughput: one item per cycle while the result port is not stalled, set by the
// single store port and the pointer and count update of the level controller
// reset: synchronous active low; bands return to 89/79/69/59, all levels
// empty, pipeline cleared; store contents are left as they are
`default_nettype none
`include "assert_macros.svh"
module banded_priority_multi_fifo #(
    parameter int LEVEL_DEPTH = bpmf_pkg::DEF_LEVEL_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bpmf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bpmf_pkg::VAL_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [6:0] value
    input  wire logic [0:0]                    s_axis_tuser,   // [0] func
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [15:0]                        m_axis_tdata,   // [6:0] out_value, [9:7] level
    output logic [2:0]                         m_axis_tuser    // [2:0] status
);
    import bpmf_pkg::*;

    localparam int STORE_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    t_bands            r_bands;
    t_op_info          op_info;
    logic              accept;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [VAL_W-1:0]  ram_q;

    logic              r_s1_valid;
    t_op_info          r_s1_info;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [LVL_W-1:0]  r_out_level;
    logic [VAL_W-1:0]  r_out_value;
    logic              out_adv;
    logic              s1_adv;

    // band registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands[0] <= BAND_TOP_RST;
            r_bands[1] <= BAND_SECOND_RST;
            r_bands[2] <= BAND_THIRD_RST;
            r_bands[3] <= BAND_FOURTH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BAND_TOP:    r_bands[0] <= i_cfg_data;
                CFG_BAND_SECOND: r_bands[1] <= i_cfg_data;
                CFG_BAND_THIRD:  r_bands[2] <= i_cfg_data;
                CFG_BAND_FOURTH: r_bands[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake chain: result register, then store-read stage
    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && out_adv;
    assign s_axis_tready = !r_s1_valid || out_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bpmf_ctrl #(
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_func     (s_axis_tuser[0]),
        .i_value    (s_axis_tdata[VAL_W-1:0]),
        .i_bands    (r_bands),
        .o_info     (op_info),
        .o_ram_we   (ram_we),
        .o_ram_re   (ram_re),
        .o_ram_addr (ram_addr)
    );

    bpmf_ram #(
        .WIDTH (VAL_W),
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (s_axis_tdata[VAL_W-1:0]),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    // store-read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_info <= op_info;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= r_s1_info.status;
            r_out_level  <= r_s1_info.level;
            r_out_value  <= r_s1_info.is_deq ? ram_q : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'd0, r_out_level, r_out_value};

    // checks
    `BPMF_ASSERT_NEXT(a_accept_fills_s1, accept, r_s1_valid,
        "accepted item did not reach the store-read stage")
    `BPMF_ASSERT_NEXT(a_s1_holds, r_s1_valid && !out_adv,
        r_s1_valid && $stable(r_s1_info),
        "stalled store-read stage lost its item")
    `BPMF_ASSERT_IMPL(a_value_zero, m_axis_tvalid && (m_axis_tuser != ST_DEQ),
        m_axis_tdata[VAL_W-1:0] == '0,
        "non-dequeue result carries a value")

endmodule
`default_nettype wire

FILE: tb/sv/tb_banded_priority_multi_fifo.sv
// testbench for the banded priority multi fifo: directed table, random phases, self-checking
`default_nettype none
module tb_banded_priority_multi_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import bpmf_pkg::*;

    localparam int DEPTH          = DEF_LEVEL_DEPTH;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // one result item as the block reports it
    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic [LVL_W-1:0] level;
    } t_qresult;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic             func;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_status          status;
        logic [VAL_W-1:0] out_value;
        logic [LVL_W-1:0] level;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIR_TAB [DIR_ROWS] = '{
        '{FUNC_DEQ, 7'd0,   1'b1, ST_EMPTY, 7'd0, 3'd0},
        '{FUNC_DEQ, 7'd127, 1'b1, ST_EMPTY, 7'd0, 3'd0},
        '{FUNC_ENQ, 7'd0,   1'b1, ST_RANGE, 7'd0, 3'd0},
        '{FUNC_ENQ, 7'd49,  1'b1, ST_RANGE, 7'd0, 3'd0},
        '{FUNC_ENQ, 7'd101, 1'b1, ST_RANGE, 7'd0, 3'd0},
        '{FUNC_ENQ, 7'd127, 1'b1, ST_RANGE, 7'd0, 3'd0},
        '{FUNC_ENQ, 7'd50,  1'b1, ST_ENQ,   7'd0, 3'd4},
        '{FUNC_ENQ, 7'd100, 1'b1, ST_ENQ,   7'd0, 3'd0},
        '{FUNC_ENQ, 7'd90,  1'b1, ST_ENQ,   7'd0, 3'd0},
        '{FUNC_ENQ, 7'd89,  1'b1, ST_ENQ,   7'd0, 3'd1},
        '{FUNC_ENQ, 7'd80,  1'b1, ST_ENQ,   7'd0, 3'd1},
        '{FUNC_ENQ, 7'd79,  1'b1, ST_ENQ,   7'd0, 3'd2},
        '{FUNC_ENQ, 7'd70,  1'b1, ST_ENQ,   7'd0, 3'd2},
        '{FUNC_ENQ, 7'd69,  1'b1, ST_ENQ,   7'd0, 3'd3},
        '{FUNC_ENQ, 7'd60,  1'b1, ST_ENQ,   7'd0, 3'd3},
        '{FUNC_ENQ, 7'd59,  1'b1, ST_ENQ,   7'd0, 3'd4},
        '{FUNC_DEQ, 7'd85,  1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd127, 1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd0,   1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd42,  1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd64,  1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd1,   1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd99,  1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd33,  1'b0, ST_DEQ,   7'd0, 3'd0},
        '{FUNC_DEQ, 7'd77,  1'b0, ST_DEQ,   7'd0, 3'd0}
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [VAL_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [6:0] value
    logic [0:0]           s_axis_tuser  = '0;   // [0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;         // [6:0] out_value, [9:7] level
    logic [2:0]           m_axis_tuser;         // [2:0] status

    // shadow of the band registers and the five levels
    logic [VAL_W-1:0] band_top, band_second, band_third, band_fourth;
    logic [VAL_W-1:0] lvl_mem  [NUM_LEVELS][DEPTH];
    int               lvl_head [NUM_LEVELS];
    int               lvl_tail [NUM_LEVELS];
    int               lvl_cnt  [NUM_LEVELS];

    t_qresult pending_outcomes[$];
    t_dir_row typed_rows[$];
    int       err_cnt = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       rx_stall_left = 0;
    int       quiet_cycles = 0;

    banded_priority_multi_fifo #(.LEVEL_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // gap length: mostly short, some medium, a few long
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // enqueue values: mostly in range, the rest below or above it
    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80) return VAL_W'($urandom_range(50, 100));
        if (roll < 90) return VAL_W'($urandom_range(0, 49));
        return VAL_W'($urandom_range(101, 127));
    endfunction

    // apply one enqueue or dequeue to the shadow levels and return its outcome
    function automatic t_qresult apply_queue_op(logic op, logic [VAL_W-1:0] v);
        t_qresult r;
        int       lv;
        logic     found;
        r = '{ST_EMPTY, '0, '0};
        found = 1'b0;
        if (op == FUNC_ENQ) begin
            if (v < VALUE_MIN || v > VALUE_MAX) begin
                r.status = ST_RANGE;
            end else begin
                // first matching band wins, even when the bands are out of order
                if (v > band_top)         lv = 0;
                else if (v > band_second) lv = 1;
                else if (v > band_third)  lv = 2;
                else if (v > band_fourth) lv = 3;
                else                      lv = 4;
                r.level = LVL_W'(lv);
                if (lvl_cnt[lv] >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    lvl_mem[lv][lvl_tail[lv]] = v;
                    lvl_tail[lv] = (lvl_tail[lv] + 1) % DEPTH;
                    lvl_cnt[lv]++;
                    r.status = ST_ENQ;
                end
            end
        end else begin
            for (int i = 0; i < NUM_LEVELS && !found; i++) begin
                if (lvl_cnt[i] != 0) begin
                    r.value  = lvl_mem[i][lvl_head[i]];
                    r.level  = LVL_W'(i);
                    r.status = ST_DEQ;
                    lvl_head[i] = (lvl_head[i] + 1) % DEPTH;
                    lvl_cnt[i]--;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // track accepted items, predict their results and check the results
    always @(posedge i_clk) begin : track
        t_qresult want;
        t_dir_row row;
        if (!i_rst_n) begin
            band_top    = BAND_TOP_RST;
            band_second = BAND_SECOND_RST;
            band_third  = BAND_THIRD_RST;
            band_fourth = BAND_FOURTH_RST;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                lvl_head[i] = 0;
                lvl_tail[i] = 0;
                lvl_cnt[i]  = 0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BAND_TOP:    band_top    = i_cfg_data;
                    CFG_BAND_SECOND: band_second = i_cfg_data;
                    CFG_BAND_THIRD:  band_third  = i_cfg_data;
                    CFG_BAND_FOURTH: band_fourth = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = apply_queue_op(s_axis_tuser[0], s_axis_tdata[VAL_W-1:0]);
                if (typed_rows.size() != 0) begin
                    row = typed_rows.pop_front();
                    if (row.typed) want = '{row.status, row.out_value, row.level};
                end
                pending_outcomes.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result item with no expected result waiting");
                    err_cnt++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        err_cnt++;
                    end
                    if (m_axis_tdata[6:0] !== want.value) begin
                        $error("out_value: expected %0d, got %0d", want.value,
                               m_axis_tdata[6:0]);
                        err_cnt++;
                    end
                    if (m_axis_tdata[9:7] !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level,
                               m_axis_tdata[9:7]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
            rx_stall_left <= gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one item, at times with a random gap ahead of it
    task automatic push_item(input logic op, input logic [VAL_W-1:0] v);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, v};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the input side until every expected result is back and the pipe is empty
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // write all four bands plus one random index past the last band, which must be ignored
    task automatic set_bands(input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] s,
                             input logic [VAL_W-1:0] th, input logic [VAL_W-1:0] f);
        wait_quiet();
        cfg_write(CFG_BAND_TOP, t);
        cfg_write(CFG_BAND_SECOND, s);
        cfg_write(CFG_BAND_THIRD, th);
        cfg_write(CFG_BAND_FOURTH, f);
        cfg_write(CFG_BAND_FOURTH + CFG_IDX_W'($urandom_range(1, 4)),
                  VAL_W'($urandom_range(127)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int n_items, input int enq_pct);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 2) wait_quiet();
            if ($urandom_range(99) < enq_pct) push_item(FUNC_ENQ, pick_value());
            else push_item(FUNC_DEQ, VAL_W'($urandom_range(127)));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset bands, no idling
        foreach (DIR_TAB[r]) begin
            typed_rows.push_back(DIR_TAB[r]);
            push_item(DIR_TAB[r].func, DIR_TAB[r].value);
        end
        idle_pct  = 30;
        stall_pct = 30;
        run_random(60, 50);

        // wide bands: mostly enqueues, filling the levels until they refuse
        set_bands(7'd127, 7'd100, 7'd75, 7'd50);
        idle_pct  = 10;
        stall_pct = 60;
        run_random(130, 85);
        idle_pct  = 50;
        stall_pct = 10;
        run_random(100, 80);

        // all bands at zero: every valid value lands in the top level
        set_bands(7'd0, 7'd0, 7'd0, 7'd0);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(60, 75);

        // all bands at the maximum: every valid value lands in the bottom level
        set_bands(7'd127, 7'd127, 7'd127, 7'd127);
        idle_pct  = 40;
        stall_pct = 40;
        run_random(60, 60);

        // bands out of order
        set_bands(7'd60, 7'd90, 7'd127, 7'd0);
        run_random(60, 50);

        // random band settings
        for (int p = 0; p < 2; p++) begin
            set_bands(VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)),
                      VAL_W'($urandom_range(127)), VAL_W'($urandom_range(127)));
            idle_pct  = $urandom_range(0, 50);
            stall_pct = $urandom_range(0, 50);
            run_random(60, 55);
        end

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
